// ----- hdl/isp_pkg.sv -----
// isp_pkg: shared types and constants of the ip stride prefetcher
// controller command and datapath status structs, state encoding, register indexes
// no dependencies
package isp_pkg;

  localparam int FIELD_W    = 48;
  localparam int CONF_W     = 16;
  localparam int THR_W      = 8;
  localparam int DEG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 8'd2;
  localparam logic [DEG_W-1:0] DEG_RESET = 4'd3;
  localparam logic             EN_RESET  = 1'b1;

  localparam logic [DEG_W-1:0]         MAX_DEG  = 4'd8;
  localparam logic signed [CONF_W-1:0] CONF_MAX = 16'sh7fff;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic scan_en;
    logic calc;
    logic write;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic emit_go;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

endpackage

// ----- hdl/isp_ram.sv -----
// isp_ram: generic single write port memory with registered read
// no dependencies
module isp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/isp_datapath.sv -----
// isp_datapath: tracker table, table scan, stride update, prefetch emission, config registers
// depends on isp_pkg and isp_ram
module isp_datapath #(
  parameter int TRACKERS   = 64,
  parameter int BLOCK_BITS = 6,
  parameter int PAGE_BITS  = 12,
  parameter int ADDR_BITS  = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  isp_pkg::ctrl_cmd_t                   cmd,
  output isp_pkg::dp_stat_t                    stat,
  input  logic [isp_pkg::FIELD_W-1:0]          in_instr_pointer,
  input  logic [isp_pkg::FIELD_W-1:0]          in_access_addr,
  input  logic                                 cfg_wr_en,
  input  logic [isp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [isp_pkg::FIELD_W-1:0]          out_prefetch_addr,
  output logic                                 out_last_of_run
);
  import isp_pkg::*;

  localparam int IDX_W   = $clog2(TRACKERS);
  localparam int CNT_W   = $clog2(TRACKERS + 1);
  localparam int LINE_W  = ADDR_BITS - BLOCK_BITS;
  localparam int STR_W   = LINE_W + 1;
  localparam int PLB     = PAGE_BITS - BLOCK_BITS;
  localparam int POS_W   = PLB + 2;
  localparam int ENTRY_W = FIELD_W + LINE_W + STR_W + CONF_W;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TRACKERS);

  // config registers
  logic [THR_W-1:0] thr_r;
  logic [DEG_W-1:0] deg_r;
  logic             en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      deg_r <= DEG_RESET;
      en_r  <= EN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_wdata;
        REG_DEGREE:    deg_r <= cfg_wdata[DEG_W-1:0];
        REG_ENABLE:    en_r  <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  // input word
  logic [FIELD_W-1:0]   ptr_r;
  logic [LINE_W-1:0]    line_r;
  logic [ADDR_BITS-1:0] addr_ext;

  assign addr_ext = ADDR_BITS'(in_access_addr);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr_r  <= in_instr_pointer;
      line_r <= addr_ext[ADDR_BITS-1:BLOCK_BITS];
    end
  end

  // table memory
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CNT_W-1:0]   idx_r;

  isp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TRACKERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  logic [FIELD_W-1:0]       rd_ptr;
  logic [LINE_W-1:0]        rd_last;
  logic signed [STR_W-1:0]  rd_stride;
  logic signed [CONF_W-1:0] rd_conf;

  assign rd_ptr    = ram_rdata[ENTRY_W-1 -: FIELD_W];
  assign rd_last   = ram_rdata[CONF_W+STR_W +: LINE_W];
  assign rd_stride = $signed(ram_rdata[CONF_W +: STR_W]);
  assign rd_conf   = $signed(ram_rdata[CONF_W-1:0]);

  // scan over the table, one entry a cycle
  logic                     pend_r;
  logic [IDX_W-1:0]         pend_idx_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         hit_idx_r;
  logic [LINE_W-1:0]        hit_last_r;
  logic signed [STR_W-1:0]  hit_stride_r;
  logic signed [CONF_W-1:0] hit_conf_r;
  logic signed [CONF_W-1:0] min_r;
  logic [IDX_W-1:0]         victim_r;
  logic                     rd_go;
  logic                     chk;
  logic                     hit_now;

  assign rd_go   = cmd.scan_en && !hit_r && (idx_r != CNT_END);
  assign chk     = pend_r && !hit_r;
  assign hit_now = chk && (rd_ptr == ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (cmd.load) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      if (cmd.clr_en || rd_go) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      pend_r <= rd_go;
      if (hit_now) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= idx_r[IDX_W-1:0];
    if (hit_now) begin
      hit_idx_r    <= pend_idx_r;
      hit_last_r   <= rd_last;
      hit_stride_r <= rd_stride;
      hit_conf_r   <= rd_conf;
    end
    if (chk && ((pend_idx_r == '0) || (rd_conf < min_r))) begin
      min_r    <= rd_conf;
      victim_r <= pend_idx_r;
    end
  end

  // stride and update
  logic signed [STR_W-1:0]  stride_r;
  logic                     same;
  logic                     nonzero;
  logic signed [CONF_W-1:0] conf_inc;
  logic signed [CONF_W-1:0] conf_new;
  logic [STR_W-PLB-1:0]     str_hi;
  logic                     in_page;
  logic signed [POS_W-1:0]  pos0;
  logic                     pos0_ok;
  logic                     qualify;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      stride_r <= $signed({1'b0, line_r}) - $signed({1'b0, hit_last_r});
    end
  end

  assign same     = (stride_r == hit_stride_r);
  assign nonzero  = (stride_r != '0);
  assign conf_inc = (hit_conf_r == CONF_MAX) ? hit_conf_r : hit_conf_r + CONF_W'(1);
  assign conf_new = same ? conf_inc : '0;
  assign str_hi   = stride_r[STR_W-1:PLB];
  assign in_page  = (~|str_hi) || ((&str_hi) && (|stride_r[PLB-1:0]));
  assign pos0     = $signed({2'b00, line_r[PLB-1:0]}) + $signed(stride_r[POS_W-1:0]);
  assign pos0_ok  = (pos0[POS_W-1:PLB] == '0);
  assign qualify  = hit_r && nonzero && same && en_r && (deg_r != '0) && in_page && pos0_ok
                    && (conf_inc > $signed({{(CONF_W-THR_W){1'b0}}, thr_r}));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = {FIELD_W'(0), LINE_W'(0), STR_W'(0), CONF_W'(0) - CONF_W'(idx_r)};
    if (cmd.clr_en) begin
      ram_we = 1'b1;
    end else if (cmd.write) begin
      if (hit_r) begin
        ram_we    = nonzero;
        ram_waddr = hit_idx_r;
        ram_wdata = {ptr_r, line_r, stride_r, conf_new};
      end else begin
        ram_we    = 1'b1;
        ram_waddr = victim_r;
        ram_wdata = {ptr_r, line_r, STR_W'(0), CONF_W'(0)};
      end
    end
  end

  // emission along the stride
  logic signed [POS_W-1:0] pos_r;
  logic signed [POS_W-1:0] step_r;
  logic [DEG_W-1:0]        k_r;
  logic signed [POS_W-1:0] pos_next;
  logic [DEG_W-1:0]        deg_eff;
  logic                    emit_last;
  logic [LINE_W-1:0]       pf_line;
  logic [ADDR_BITS-1:0]    pf_addr;

  assign pos_next  = pos_r + step_r;
  assign deg_eff   = (deg_r > MAX_DEG) ? MAX_DEG : deg_r;
  assign emit_last = (k_r == deg_eff) || (pos_next[POS_W-1:PLB] != '0);
  assign pf_line   = {line_r[LINE_W-1:PLB], pos_r[PLB-1:0]};
  assign pf_addr   = {pf_line, {BLOCK_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      pos_r  <= pos0;
      step_r <= stride_r[POS_W-1:0];
      k_r    <= DEG_W'(1);
    end else if (cmd.emit) begin
      pos_r <= pos_next;
      k_r   <= k_r + DEG_W'(1);
    end
  end

  // output register
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_addr_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_addr_r <= FIELD_W'(pf_addr);
      out_last_r <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_prefetch_addr = out_addr_r;
  assign out_last_of_run   = out_last_r;

  assign stat.clr_done  = (idx_r == CNT_END);
  assign stat.scan_done = hit_r || ((idx_r == CNT_END) && !pend_r);
  assign stat.emit_go   = qualify;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.emit_last = emit_last;

endmodule

// ----- hdl/isp_ctrl.sv -----
// isp_ctrl: sequencing state machine of the ip stride prefetcher
// depends on isp_pkg
module isp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  isp_pkg::dp_stat_t  stat,
  output isp_pkg::ctrl_cmd_t cmd
);
  import isp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = stat.emit_go ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free && stat.emit_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = !stat.clr_done;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/ip_stride_prefetcher_core.sv -----
// ip_stride_prefetcher_core: top level of the ip indexed stride prefetcher
// depends on isp_pkg, isp_ctrl, isp_datapath, isp_ram
//
// After reset the tracker table is swept once, with one entry written per cycle, before the
// first access is taken; configuration writes are taken at any time. Each access then walks
// the table through the single read port of the table memory, one entry per cycle: a pointer
// hit ends the walk at the hit entry, a miss walks every entry. The CALC and WRITE states then
// form the stride and write the entry back, and a qualifying access then sends out one
// prefetch word per cycle, up to eight, while the output is not stalled.
// The output register lets the next access enter while the last prefetch word still waits.
module ip_stride_prefetcher_core #(
  parameter int TRACKERS   = 64,
  parameter int BLOCK_BITS = 6,
  parameter int PAGE_BITS  = 12,
  parameter int ADDR_BITS  = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [isp_pkg::FIELD_W-1:0]    in_instr_pointer,
  input  logic [isp_pkg::FIELD_W-1:0]    in_access_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [isp_pkg::FIELD_W-1:0]    out_prefetch_addr,
  output logic                           out_last_of_run,
  input  logic                           cfg_wr_en,
  input  logic [isp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import isp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  isp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  isp_datapath #(
    .TRACKERS   (TRACKERS),
    .BLOCK_BITS (BLOCK_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_instr_pointer  (in_instr_pointer),
    .in_access_addr    (in_access_addr),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prefetch_addr (out_prefetch_addr),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

// ----- hdl/isp_checker.sv -----
// isp_checker: port level checks of the ip stride prefetcher
// bound to ip_stride_prefetcher_core, no other dependencies
module isp_checker #(
  parameter int BLOCK_BITS = 6
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_prefetch_addr,
  input logic        out_last_of_run
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prefetch_addr)
                               && $stable(out_last_of_run))
    else $error("stalled output word changed");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_prefetch_addr[BLOCK_BITS-1:0] == '0))
    else $error("prefetch address not block aligned");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared right after accept");

endmodule

bind ip_stride_prefetcher_core isp_checker #(.BLOCK_BITS(BLOCK_BITS)) u_isp_checker (.*);
